FILE: rtl/wfpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfpa_pkg: shared types and constants of the worst-fit partition allocator
// Holds field widths, status codes, cell commands and controller states.
// ----------------------------------------------------------------------------
package wfpa_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int OFFSET_BITS = 20;
  localparam int SIZE_W      = 21;
  localparam int ID_W        = 8;
  localparam int START_W     = 20;
  localparam longint MEM_RESET = 1048576;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_INIT,
    CMD_USE,
    CMD_FREE,
    CMD_INSERT
  } cell_op_t;

  typedef struct packed {
    cell_op_t        op;
    logic [ID_W-1:0] owner;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

FILE: rtl/worst_fit_partition_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// worst_fit_partition_allocator: worst-fit partition table on a cell chain
// A search token walks the chain, one cell per cycle, in S_SCAN; S_DONE then
// applies the table update and sets done through its register. busy is high
// from S_SCAN through S_DONE, so no new request is taken until the last one
// is through. done pulses for one cycle and is not stalled.
// Reset (and a memory_size write taken while idle) leaves one free hole
// covering the whole memory, and needs no clearing pass.
// ----------------------------------------------------------------------------
module worst_fit_partition_allocator #(
  parameter int TABLE_DEPTH = wfpa_pkg::TABLE_DEPTH,
  parameter int OFFSET_BITS = wfpa_pkg::OFFSET_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         memory_size_we,
  input  logic [wfpa_pkg::SIZE_W-1:0]  memory_size,
  input  logic                         start,
  output logic                         busy,
  input  logic                         func,
  input  logic [wfpa_pkg::ID_W-1:0]    owner_id,
  input  logic [wfpa_pkg::SIZE_W-1:0]  req_size,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [wfpa_pkg::START_W-1:0] start_offset
);

  localparam int LEN_W = OFFSET_BITS + 1;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (LEN_W > wfpa_pkg::SIZE_W) ? LEN_W : wfpa_pkg::SIZE_W;
  localparam logic [CMP_W-1:0] LIMIT   = CMP_W'(longint'(1) << OFFSET_BITS);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TABLE_DEPTH - 1);

  wfpa_pkg::state_t    state, state_next;
  wfpa_pkg::cell_cmd_t cmd;
  logic [IDX_W-1:0]    cmd_idx;
  logic [LEN_W-1:0]    cmd_val;
  logic [CNT_W-1:0]    count, count_next;
  logic [IDX_W-1:0]    step;
  logic                req_func;
  logic [wfpa_pkg::ID_W-1:0]   req_id;
  logic [wfpa_pkg::SIZE_W-1:0] req_len;
  logic                         done_next;
  wfpa_pkg::status_t            status_next;
  logic [wfpa_pkg::START_W-1:0] offset_next;

  // Chain wiring: index k is the input of cell k, k+1 its output
  logic                      c_free  [TABLE_DEPTH+1];
  logic [wfpa_pkg::ID_W-1:0] c_owner [TABLE_DEPTH+1];
  logic [OFFSET_BITS-1:0]    c_start [TABLE_DEPTH+1];
  logic [LEN_W-1:0]          c_len   [TABLE_DEPTH+1];
  logic [LEN_W-1:0]          t_len   [TABLE_DEPTH+1];
  logic [IDX_W-1:0]          t_idx   [TABLE_DEPTH+1];
  logic                      t_hit   [TABLE_DEPTH+1];
  logic [OFFSET_BITS-1:0]    t_start [TABLE_DEPTH+1];

  logic [CMP_W-1:0] size_w;
  logic [CMP_W-1:0] req_w;
  logic [CMP_W-1:0] best_w;
  logic             no_fit;

  assign c_free[0]  = 1'b0;
  assign c_owner[0] = '0;
  assign c_start[0] = '0;
  assign c_len[0]   = '0;
  assign t_len[0]   = '0;
  assign t_idx[0]   = '0;
  assign t_hit[0]   = 1'b0;
  assign t_start[0] = '0;

  genvar k;
  generate
    for (k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      wfpa_cell #(
        .LEN_W(LEN_W), .OFF_W(OFFSET_BITS), .IDX_W(IDX_W), .CNT_W(CNT_W), .CELL_IDX(k)
      ) u_cell (
        .clk(clk), .rst(rst),
        .cmd(cmd), .cmd_idx(cmd_idx), .cmd_val(cmd_val), .count(count),
        .scan_func(req_func), .scan_id(req_id),
        .prev_free(c_free[k]), .prev_owner(c_owner[k]),
        .prev_start(c_start[k]), .prev_len(c_len[k]),
        .tin_len(t_len[k]), .tin_idx(t_idx[k]), .tin_hit(t_hit[k]),
        .tin_start(t_start[k]),
        .free(c_free[k+1]), .owner(c_owner[k+1]),
        .start(c_start[k+1]), .len(c_len[k+1]),
        .tout_len(t_len[k+1]), .tout_idx(t_idx[k+1]), .tout_hit(t_hit[k+1]),
        .tout_start(t_start[k+1])
      );
    end
  endgenerate

  assign size_w = CMP_W'(memory_size);
  assign req_w  = CMP_W'(req_len);
  assign best_w = CMP_W'(t_len[TABLE_DEPTH]);
  assign no_fit = (best_w == '0) || (req_w == '0) || (req_w > best_w);
  assign busy   = state != wfpa_pkg::S_IDLE;

  // Hold state, count, request and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wfpa_pkg::S_IDLE;
      count <= CNT_W'(1);
      step  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
      step  <= (state == wfpa_pkg::S_SCAN) ? step + IDX_W'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_func <= func;
      req_id   <= owner_id;
      req_len  <= req_size;
    end
    status       <= status_next;
    start_offset <= offset_next;
  end

  // Sequence the scan and decide the table update
  always_comb begin
    state_next  = state;
    count_next  = count;
    cmd.op      = wfpa_pkg::CMD_NONE;
    cmd.owner   = req_id;
    cmd_idx     = t_idx[TABLE_DEPTH];
    cmd_val     = LEN_W'(req_w);
    done_next   = 1'b0;
    status_next = wfpa_pkg::ST_OK;
    offset_next = '0;
    unique case (state)
      wfpa_pkg::S_IDLE: begin
        if (memory_size_we) begin
          cmd.op     = wfpa_pkg::CMD_INIT;
          cmd_val    = LEN_W'((size_w > LIMIT) ? LIMIT : size_w);
          count_next = CNT_W'(1);
        end
        if (start) begin
          state_next = wfpa_pkg::S_SCAN;
        end
      end
      wfpa_pkg::S_SCAN: begin
        if (step == LAST_STEP) state_next = wfpa_pkg::S_DONE;
      end
      wfpa_pkg::S_DONE: begin
        state_next = wfpa_pkg::S_IDLE;
        done_next  = 1'b1;
        if (req_func) begin
          if (t_hit[TABLE_DEPTH]) cmd.op = wfpa_pkg::CMD_FREE;
          else status_next = wfpa_pkg::ST_NOT_FOUND;
        end else if (no_fit) begin
          status_next = wfpa_pkg::ST_NO_FIT;
        end else if (req_w == best_w) begin
          cmd.op      = wfpa_pkg::CMD_USE;
          offset_next = wfpa_pkg::START_W'(t_start[TABLE_DEPTH]);
        end else if (count == FULL_CNT) begin
          status_next = wfpa_pkg::ST_FULL;
        end else begin
          cmd.op      = wfpa_pkg::CMD_INSERT;
          count_next  = count + CNT_W'(1);
          offset_next = wfpa_pkg::START_W'(t_start[TABLE_DEPTH]);
        end
      end
      default: state_next = wfpa_pkg::S_IDLE;
    endcase
  end

  // A result only follows a finished scan
  a_done_after_scan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == wfpa_pkg::S_DONE))
    else $error("done without a finished scan");

  // The table never empties nor overflows
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= FULL_CNT))
    else $error("entry count out of range");

  // An accepted item always yields a result after the full chain walk
  a_scan_length: assert property (@(posedge clk) disable iff (rst)
    (state == wfpa_pkg::S_SCAN) && (step == LAST_STEP) |=> ##1 done)
    else $error("result missing after scan");

  // A failed request leaves the offset at zero
  a_zero_offset: assert property (@(posedge clk) disable iff (rst)
    done && (status != wfpa_pkg::ST_OK) |-> (start_offset == '0))
    else $error("offset set on a failed request");

endmodule

FILE: rtl/wfpa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfpa_cell: one table entry of the allocator chain
// Holds one partition, passes the search token on to its neighbor each
// cycle and shifts entries down on an insertion.
// ----------------------------------------------------------------------------
module wfpa_cell #(
  parameter int LEN_W    = wfpa_pkg::OFFSET_BITS + 1,
  parameter int OFF_W    = wfpa_pkg::OFFSET_BITS,
  parameter int IDX_W    = 6,
  parameter int CNT_W    = 7,
  parameter int CELL_IDX = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  wfpa_pkg::cell_cmd_t       cmd,
  input  logic [IDX_W-1:0]          cmd_idx,
  input  logic [LEN_W-1:0]          cmd_val,
  input  logic [CNT_W-1:0]          count,
  input  logic                      scan_func,
  input  logic [wfpa_pkg::ID_W-1:0] scan_id,
  input  logic                      prev_free,
  input  logic [wfpa_pkg::ID_W-1:0] prev_owner,
  input  logic [OFF_W-1:0]          prev_start,
  input  logic [LEN_W-1:0]          prev_len,
  input  logic [LEN_W-1:0]          tin_len,
  input  logic [IDX_W-1:0]          tin_idx,
  input  logic                      tin_hit,
  input  logic [OFF_W-1:0]          tin_start,
  output logic                      free,
  output logic [wfpa_pkg::ID_W-1:0] owner,
  output logic [OFF_W-1:0]          start,
  output logic [LEN_W-1:0]          len,
  output logic [LEN_W-1:0]          tout_len,
  output logic [IDX_W-1:0]          tout_idx,
  output logic                      tout_hit,
  output logic [OFF_W-1:0]          tout_start
);

  localparam longint LIMIT = longint'(1) << OFF_W;
  localparam logic [LEN_W-1:0] RST_LEN =
    LEN_W'((wfpa_pkg::MEM_RESET > LIMIT) ? LIMIT : wfpa_pkg::MEM_RESET);
  localparam logic [IDX_W-1:0] ME     = IDX_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] ME_CNT = CNT_W'(CELL_IDX);

  logic                 active;
  logic                 at_idx;
  logic                 after_idx;
  logic                 beyond_idx;
  logic [IDX_W:0]       idx_p1;

  assign active     = ME_CNT < count;
  assign idx_p1     = {1'b0, cmd_idx} + (IDX_W+1)'(1);
  assign at_idx     = cmd_idx == ME;
  assign after_idx  = idx_p1 == {1'b0, ME};
  assign beyond_idx = {1'b0, ME} > idx_p1;

  // Advance the search token: widest free hole on store, first owner match on remove
  always_ff @(posedge clk) begin
    if (active && !scan_func && free && (len > tin_len)) begin
      tout_len   <= len;
      tout_idx   <= ME;
      tout_hit   <= tin_hit;
      tout_start <= start;
    end else if (active && scan_func && !tin_hit && (owner == scan_id)) begin
      tout_len   <= tin_len;
      tout_idx   <= ME;
      tout_hit   <= 1'b1;
      tout_start <= tin_start;
    end else begin
      tout_len   <= tin_len;
      tout_idx   <= tin_idx;
      tout_hit   <= tin_hit;
      tout_start <= tin_start;
    end
  end

  // Update the entry on a table command
  always_ff @(posedge clk) begin
    if (rst) begin
      free  <= (CELL_IDX == 0);
      owner <= '0;
      start <= '0;
      len   <= (CELL_IDX == 0) ? RST_LEN : '0;
    end else begin
      unique case (cmd.op)
        wfpa_pkg::CMD_INIT: begin
          free  <= (CELL_IDX == 0);
          owner <= '0;
          start <= '0;
          len   <= (CELL_IDX == 0) ? cmd_val : '0;
        end
        wfpa_pkg::CMD_USE: begin
          if (at_idx) begin
            free  <= 1'b0;
            owner <= cmd.owner;
          end
        end
        wfpa_pkg::CMD_FREE: begin
          if (at_idx) begin
            free  <= 1'b1;
            owner <= '0;
          end
        end
        wfpa_pkg::CMD_INSERT: begin
          if (at_idx) begin
            free  <= 1'b0;
            owner <= cmd.owner;
            len   <= cmd_val;
          end else if (after_idx) begin
            free  <= prev_free;
            owner <= prev_owner;
            start <= prev_start + OFF_W'(cmd_val);
            len   <= prev_len - cmd_val;
          end else if (beyond_idx) begin
            free  <= prev_free;
            owner <= prev_owner;
            start <= prev_start;
            len   <= prev_len;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: bench/tb_worst_fit_partition_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_worst_fit_partition_allocator: self-checking bench of the allocator
// Drives store and remove commands with random bursts and gaps, predicts each
// status and start offset from a behavioral copy of the partition table, and
// compares every done pulse with the oldest prediction. Several memory sizes
// are programmed between phases, the smallest and largest among them.
// ----------------------------------------------------------------------------
module tb_worst_fit_partition_allocator;

  localparam int DEPTH = wfpa_pkg::TABLE_DEPTH;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef struct {
    logic                        func;
    logic [wfpa_pkg::ID_W-1:0]   owner;
    logic [wfpa_pkg::SIZE_W-1:0] req;
  } alloc_cmd_t;

  typedef struct {
    wfpa_pkg::status_t            stat;
    logic [wfpa_pkg::START_W-1:0] offset;
  } alloc_resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic memory_size_we = 1'b0;
  logic [wfpa_pkg::SIZE_W-1:0] memory_size = '0;
  logic start = 1'b0;
  logic busy;
  logic func = 1'b0;
  logic [wfpa_pkg::ID_W-1:0] owner_id = '0;
  logic [wfpa_pkg::SIZE_W-1:0] req_size = '0;
  logic done;
  logic [1:0] status;
  logic [wfpa_pkg::START_W-1:0] start_offset;

  // Predictor copy of the partition table
  logic                      tbl_free [DEPTH];
  logic [wfpa_pkg::ID_W-1:0] tbl_owner[DEPTH];
  logic [21:0]               tbl_start[DEPTH];
  logic [21:0]               tbl_len  [DEPTH];
  int                        tbl_count;
  logic [21:0]               mem_bytes;

  alloc_cmd_t  pending_cmds[$];
  alloc_resp_t expected_resps[$];
  int   errors = 0;
  int   idle_cycles = 0;
  int   burst_left = 0;
  int   gap_left = 0;
  bit   hold_for_drain = 1'b0;
  bit   feed_done = 1'b0;

  worst_fit_partition_allocator uut (
    .clk(clk), .rst(rst), .memory_size_we(memory_size_we), .memory_size(memory_size),
    .start(start), .busy(busy), .func(func), .owner_id(owner_id), .req_size(req_size),
    .done(done), .status(status), .start_offset(start_offset)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Reinitialize the predicted table to one hole
  function automatic void table_reinit(logic [wfpa_pkg::SIZE_W-1:0] size);
    mem_bytes = (size > (1 << wfpa_pkg::OFFSET_BITS)) ?
                (22'd1 << wfpa_pkg::OFFSET_BITS) : {1'b0, size};
    for (int i = 0; i < DEPTH; i++) begin
      tbl_free[i] = 1'b0;
      tbl_owner[i] = '0;
      tbl_start[i] = '0;
      tbl_len[i] = '0;
    end
    tbl_free[0] = 1'b1;
    tbl_len[0] = mem_bytes;
    tbl_count = 1;
  endfunction

  // Compute the response of one command and update the table
  function automatic alloc_resp_t predict_alloc(alloc_cmd_t c);
    alloc_resp_t r;
    int best;
    logic [21:0] best_len;
    best = 0;
    best_len = '0;
    r.stat = wfpa_pkg::ST_OK;
    r.offset = '0;
    if (c.func == FUNC_REMOVE) begin
      r.stat = wfpa_pkg::ST_NOT_FOUND;
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_owner[i] == c.owner) begin
          tbl_free[i] = 1'b1;
          tbl_owner[i] = '0;
          r.stat = wfpa_pkg::ST_OK;
          break;
        end
      end
      return r;
    end
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_free[i] && tbl_len[i] > best_len) begin
        best_len = tbl_len[i];
        best = i;
      end
    end
    if (best_len == 0 || c.req == 0 || {1'b0, c.req} > best_len) begin
      r.stat = wfpa_pkg::ST_NO_FIT;
    end else if (tbl_len[best] == {1'b0, c.req}) begin
      tbl_free[best] = 1'b0;
      tbl_owner[best] = c.owner;
      r.offset = tbl_start[best][wfpa_pkg::START_W-1:0];
    end else if (tbl_count >= DEPTH) begin
      r.stat = wfpa_pkg::ST_FULL;
    end else begin
      for (int i = tbl_count; i > best; i--) begin
        tbl_free[i] = tbl_free[i-1];
        tbl_owner[i] = tbl_owner[i-1];
        tbl_start[i] = tbl_start[i-1];
        tbl_len[i] = tbl_len[i-1];
      end
      tbl_count++;
      tbl_free[best] = 1'b0;
      tbl_owner[best] = c.owner;
      tbl_len[best] = {1'b0, c.req};
      tbl_start[best+1] = tbl_start[best+1] + {1'b0, c.req};
      tbl_len[best+1] = tbl_len[best+1] - {1'b0, c.req};
      r.offset = tbl_start[best][wfpa_pkg::START_W-1:0];
    end
    return r;
  endfunction

  function automatic void push_cmd(logic f, logic [wfpa_pkg::ID_W-1:0] id,
                                   logic [wfpa_pkg::SIZE_W-1:0] sz);
    alloc_cmd_t c;
    c.func = f;
    c.owner = id;
    c.req = sz;
    pending_cmds.push_back(c);
  endfunction

  // Mostly small sizes so the table fills; sometimes zero, huge or full-range values
  function automatic logic [wfpa_pkg::SIZE_W-1:0] rand_size();
    case ($urandom_range(9))
      0: return wfpa_pkg::SIZE_W'($urandom_range(2097151));
      1: return wfpa_pkg::SIZE_W'($urandom_range(1048576, 1 << 19));
      2: return '0;
      default: return wfpa_pkg::SIZE_W'($urandom_range(64, 1));
    endcase
  endfunction

  // Driver: issue commands in bursts separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      // the item went in at an earlier edge and the block is free again
      start <= 1'b0;
    end else if (!start && !busy) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (hold_for_drain && expected_resps.size() != 0) begin
        // hold until everything predicted has arrived
      end else if (pending_cmds.size() != 0) begin
        alloc_cmd_t c;
        c = pending_cmds.pop_front();
        func <= c.func;
        owner_id <= c.owner;
        req_size <= c.req;
        start <= 1'b1;
        expected_resps.push_back(predict_alloc(c));
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(8);
          gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(200);
        end
      end
    end
  end

  // Monitor: check each done pulse against the oldest prediction
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done) begin
        if (expected_resps.size() == 0) begin
          $display("%0t: unexpected result status=%0d offset=%0d", $time, status,
                   start_offset);
          errors <= errors + 1;
        end else begin
          alloc_resp_t e;
          e = expected_resps.pop_front();
          if (status !== e.stat || start_offset !== e.offset) begin
            if (status !== e.stat)
              $display("%0t: status expected %0d actual %0d", $time, e.stat, status);
            if (start_offset !== e.offset)
              $display("%0t: start_offset expected %0d actual %0d", $time, e.offset,
                       start_offset);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic drain();
    wait (pending_cmds.size() == 0 && !start);
    wait (expected_resps.size() == 0);
    repeat (DEPTH + 10) @(posedge clk);
  endtask

  task automatic program_size(logic [wfpa_pkg::SIZE_W-1:0] size);
    @(negedge clk);
    memory_size <= size;
    memory_size_we <= 1'b1;
    @(negedge clk);
    memory_size_we <= 1'b0;
    table_reinit(size);
  endtask

  task automatic random_phase(int count, int id_max);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(1))
        push_cmd(FUNC_STORE, wfpa_pkg::ID_W'($urandom_range(id_max)), rand_size());
      else
        push_cmd(FUNC_REMOVE, wfpa_pkg::ID_W'($urandom_range(id_max)),
                 wfpa_pkg::SIZE_W'($urandom_range(2097151)));
    end
  endtask

  initial begin
    table_reinit(21'd1048576);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, exact fit, no fit, zero request, not found
    push_cmd(FUNC_STORE, 8'd1, 21'd0);
    push_cmd(FUNC_STORE, 8'd255, 21'd1048577);
    push_cmd(FUNC_STORE, 8'd255, 21'd2097151);
    push_cmd(FUNC_STORE, 8'd1, 21'd1);
    push_cmd(FUNC_STORE, 8'd1, 21'd100);
    push_cmd(FUNC_REMOVE, 8'd1, 21'd0);
    push_cmd(FUNC_REMOVE, 8'd1, 21'h1FFFFF);
    push_cmd(FUNC_REMOVE, 8'd77, 21'd0);
    push_cmd(FUNC_REMOVE, 8'd0, 21'd0);
    push_cmd(FUNC_STORE, 8'd200, 21'd1048475);
    push_cmd(FUNC_STORE, 8'd170, 21'd1);
    push_cmd(FUNC_STORE, 8'd85, 21'd1);
    drain();

    // Exact fit of the whole memory, then a table overflow on a small memory
    program_size(21'd1048576);
    push_cmd(FUNC_STORE, 8'd9, 21'd1048576);
    push_cmd(FUNC_STORE, 8'd9, 21'd1);
    push_cmd(FUNC_REMOVE, 8'd9, 21'd0);
    drain();
    program_size(21'd100);
    for (int i = 0; i < DEPTH + 2; i++) push_cmd(FUNC_STORE, 8'(i + 1), 21'd1);
    push_cmd(FUNC_STORE, 8'd3, 21'd37);
    drain();

    // Zero and saturated sizes
    program_size(21'd0);
    push_cmd(FUNC_STORE, 8'd4, 21'd1);
    drain();
    program_size(21'h1FFFFF);
    push_cmd(FUNC_STORE, 8'd4, 21'd1048576);
    drain();

    // Random phases over several memory sizes, one with a forced drain
    program_size(21'd1);
    random_phase(60, 3);
    drain();
    program_size(21'd500);
    random_phase(250, 15);
    hold_for_drain = 1'b1;
    random_phase(20, 255);
    drain();
    hold_for_drain = 1'b0;
    program_size(21'($urandom_range(4096, 2)));
    random_phase(300, 40);
    drain();
    program_size(21'd1048576);
    random_phase(270, 255);
    drain();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
